// ===== hw/rtl/tfc_pkg.sv =====
// Shared types and constants for the tagged response frame cache.
// Used by tfc_frame_ram, tfc_tag_dir and tagged_response_frame_cache_unit.
package tfc_pkg;

   localparam int SLOTS       = 10;
   localparam int FRAME_BYTES = 64;

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int POS_W   = $clog2(FRAME_BYTES + 1);   // fill position 0..FRAME_BYTES
   localparam int IDX_W   = $clog2(FRAME_BYTES);       // byte index 0..FRAME_BYTES-1
   localparam int LEN_W   = 7;
   localparam int DEPTH   = SLOTS * FRAME_BYTES;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] device_address;
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  length;
   } lookup_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
   } ram_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MISS,
      ST_STREAM
   } state_type;

   function automatic logic [ADDR_W-1:0] entry_addr(logic [SLOT_W-1:0] slot,
                                                    logic [IDX_W-1:0] idx);
      entry_addr = ADDR_W'(slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(idx);
   endfunction

endpackage

// ===== hw/rtl/tfc_frame_ram.sv =====
// Frame byte store: single write port, single registered read port.
// Depends on tfc_pkg for depth and address width.
module tfc_frame_ram (
   input  logic                      clock,
   input  tfc_pkg::ram_wr_type       wr,
   input  logic [7:0]                wdata,
   input  logic                      re,
   input  logic [tfc_pkg::ADDR_W-1:0] raddr,
   output logic [7:0]                rdata
);

   logic [7:0] mem [tfc_pkg::DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/tfc_tag_dir.sv =====
// Slot directory: tags, valid marks, lengths and the fill pointer.
// Does the parallel tag lookup and drives the frame RAM write address.
// Depends on tfc_pkg.
module tfc_tag_dir (
   input  logic                clock,
   input  logic                reset,
   input  logic                store_en,
   input  logic                lookup_en,
   input  tfc_pkg::req_type    req,
   output tfc_pkg::lookup_type lookup,
   output tfc_pkg::ram_wr_type wr
);

   logic [7:0]                 tag_ff   [tfc_pkg::SLOTS];
   logic [tfc_pkg::LEN_W-1:0]  len_ff   [tfc_pkg::SLOTS];
   logic [tfc_pkg::SLOTS-1:0]  valid_ff;
   logic [tfc_pkg::SLOT_W-1:0] fill_slot_ff, fill_slot_in;
   logic [tfc_pkg::POS_W-1:0]  fill_pos_ff, fill_pos_in;
   logic                       room;
   logic [tfc_pkg::POS_W-1:0]  pos_next;

   // lowest matching valid slot wins
   always_comb begin
      lookup = '0;
      for (int s = tfc_pkg::SLOTS - 1; s >= 0; s--) begin
         if (valid_ff[s] && tag_ff[s] == req.device_address) begin
            lookup.hit    = 1'b1;
            lookup.slot   = tfc_pkg::SLOT_W'(s);
            lookup.length = len_ff[s];
         end
      end
   end

   assign room     = fill_pos_ff < tfc_pkg::POS_W'(tfc_pkg::FRAME_BYTES);
   assign pos_next = room ? fill_pos_ff + 1'b1 : fill_pos_ff;
   assign wr.we    = store_en && room;
   assign wr.addr  = tfc_pkg::entry_addr(fill_slot_ff, fill_pos_ff[tfc_pkg::IDX_W-1:0]);

   always_comb begin
      fill_slot_in = fill_slot_ff;
      fill_pos_in  = fill_pos_ff;
      if (store_en) begin
         fill_pos_in = pos_next;
         if (req.frame_end) begin
            fill_pos_in  = '0;
            fill_slot_in = (fill_slot_ff == tfc_pkg::SLOT_W'(tfc_pkg::SLOTS - 1))
                           ? '0 : fill_slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fill_slot_ff <= '0;
         fill_pos_ff  <= '0;
      end else begin
         fill_slot_ff <= fill_slot_in;
         fill_pos_ff  <= fill_pos_in;
         if (store_en && req.frame_end) begin
            valid_ff[fill_slot_ff] <= 1'b1;
         end else if (lookup_en && lookup.hit) begin
            valid_ff[lookup.slot] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_en && req.frame_end) begin
         tag_ff[fill_slot_ff] <= req.device_address;
         len_ff[fill_slot_ff] <= tfc_pkg::LEN_W'(pos_next);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_pos_ff <= tfc_pkg::POS_W'(tfc_pkg::FRAME_BYTES))
      else $error("fill position past frame size");

   assert property (@(posedge clock) disable iff (reset)
      fill_slot_ff < tfc_pkg::SLOT_W'(tfc_pkg::SLOTS))
      else $error("fill slot out of range");

   assert property (@(posedge clock) disable iff (reset)
      lookup_en && lookup.hit |=> !valid_ff[$past(lookup.slot)])
      else $error("fetched slot still valid");

endmodule

// ===== hw/rtl/tagged_response_frame_cache_unit.sv =====
// Tagged response frame cache, top level.
//
// Items enter on req_item and are taken when start is high and busy is low.
// A store item (kind = 0) writes one frame byte into the current fill slot
// if it has room; busy stays low, so bytes may arrive every cycle while no
// fetch holds busy. The byte with frame_end closes the frame, tags the slot
// and moves the fill pointer to the next slot. Stores give no result.
// A fetch item (kind = 1) does a parallel tag compare in its accept cycle and
// invalidates the matching slot. On a hit the frame bytes are read from the
// frame RAM one per cycle and appear on rsp_item with rsp_valid, each read
// registered in the RAM; busy stays high while the bytes are read. A miss
// gives one result in the cycle after accept, with busy high in that cycle
// only. The rate is set by the single read port of the frame RAM. busy drops
// while the last byte is still on the result ports, so the next item may be
// taken then. Results show for one cycle each; the receiver cannot stall them.
// Synchronous reset empties all slots and rewinds the fill pointer; frame RAM
// contents are not cleared and no clearing pass is needed.
// Depends on tfc_pkg, tfc_tag_dir and tfc_frame_ram.
module tagged_response_frame_cache_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tfc_pkg::req_type req_item,
   output logic             rsp_valid,
   output tfc_pkg::rsp_type rsp_item
);

   tfc_pkg::state_type         state_ff, state_in;
   tfc_pkg::lookup_type        lookup;
   tfc_pkg::ram_wr_type        wr;
   logic [tfc_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [tfc_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [tfc_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                       hit_ff, hit_in;
   logic                       data_vld_ff, data_vld_in;
   logic                       last_ff, last_in;
   logic                       accept, store_en, lookup_en;
   logic                       issue, last_issue;
   logic [7:0]                 rdata;

   assign accept    = start && !busy;
   assign store_en  = accept && req_item.kind == tfc_pkg::KIND_STORE;
   assign lookup_en = accept && req_item.kind == tfc_pkg::KIND_FETCH;

   tfc_tag_dir u_tag_dir (
      .clock     (clock),
      .reset     (reset),
      .store_en  (store_en),
      .lookup_en (lookup_en),
      .req       (req_item),
      .lookup    (lookup),
      .wr        (wr)
   );

   tfc_frame_ram u_frame_ram (
      .clock (clock),
      .wr    (wr),
      .wdata (req_item.frame_byte),
      .re    (issue),
      .raddr (tfc_pkg::entry_addr(slot_ff, idx_ff)),
      .rdata (rdata)
   );

   assign issue      = state_ff == tfc_pkg::ST_STREAM;
   assign last_issue = issue && (tfc_pkg::LEN_W'(idx_ff) + 1'b1 == len_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tfc_pkg::ST_IDLE: begin
            if (lookup_en) begin
               state_in = (lookup.hit && lookup.length != '0)
                          ? tfc_pkg::ST_STREAM : tfc_pkg::ST_MISS;
            end
         end
         tfc_pkg::ST_MISS: begin
            state_in = tfc_pkg::ST_IDLE;
         end
         tfc_pkg::ST_STREAM: begin
            if (last_issue) begin
               state_in = tfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tfc_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      slot_in     = slot_ff;
      len_in      = len_ff;
      hit_in      = hit_ff;
      idx_in      = idx_ff;
      data_vld_in = issue;
      last_in     = last_issue;
      if (lookup_en) begin
         slot_in = lookup.slot;
         len_in  = lookup.length;
         hit_in  = lookup.hit;
         idx_in  = '0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // outputs
   always_comb begin
      busy      = 1'b0;
      rsp_valid = data_vld_ff;
      rsp_item  = '{hit: 1'b1, out_byte: rdata, out_last: last_ff};
      case (state_ff)
         tfc_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         tfc_pkg::ST_MISS: begin
            // miss, or a zero-length frame: one closing result
            busy      = 1'b1;
            rsp_valid = 1'b1;
            rsp_item  = '{hit: hit_ff, out_byte: 8'd0, out_last: 1'b1};
         end
         tfc_pkg::ST_STREAM: begin
            busy = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tfc_pkg::ST_IDLE;
         data_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         data_vld_ff <= data_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      len_ff  <= len_in;
      hit_ff  <= hit_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.hit |-> rsp_item.out_last)
      else $error("miss result not marked last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.out_last |-> busy)
      else $error("idle while a frame is still streaming");

   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && $past(req_item.kind) == tfc_pkg::KIND_FETCH)
      else $error("busy without an accepted fetch");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == tfc_pkg::ST_MISS |-> !data_vld_ff)
      else $error("two results in one cycle");

endmodule

// ===== sim/tagged_response_frame_cache_unit_test.sv =====
// Self-checking bench for tagged_response_frame_cache_unit: directed and random
// store/fetch items, with the frame cache tracked alongside the block.
// Depends on tfc_pkg and the tagged_response_frame_cache_unit RTL.
module tagged_response_frame_cache_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 1000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   tfc_pkg::req_type req_item = '0;
   logic             rsp_valid;
   tfc_pkg::rsp_type rsp_item;

   // items waiting to be offered; the head is what sits on req_item
   tfc_pkg::req_type item_q [$];
   // fetch results still owed by the block, oldest first
   tfc_pkg::rsp_type owed_rsp [$];

   // tracked cache contents
   bit [7:0] cache_tag   [tfc_pkg::SLOTS];
   bit       cache_valid [tfc_pkg::SLOTS];
   int       cache_len   [tfc_pkg::SLOTS];
   bit [7:0] cache_bytes [tfc_pkg::SLOTS][tfc_pkg::FRAME_BYTES];
   int       fill_idx;
   int       fill_pos;

   int n_taken, n_stores, n_fetches, n_hits, n_misses, n_dropped;
   int n_results, n_errors, stall_cycles;

   tagged_response_frame_cache_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #6ns clock = ~clock;

   // Track one accepted item and queue up the bytes a fetch should return.
   task automatic cache_take_item(input tfc_pkg::req_type it);
      int               s;
      int               found;
      tfc_pkg::rsp_type r;
      if (it.kind == tfc_pkg::KIND_STORE) begin
         n_stores++;
         if (fill_pos < tfc_pkg::FRAME_BYTES) begin
            cache_bytes[fill_idx][fill_pos] = it.frame_byte;
            fill_pos++;
         end else begin
            n_dropped++;
         end
         if (it.frame_end) begin
            cache_tag[fill_idx]   = it.device_address;
            cache_valid[fill_idx] = 1'b1;
            cache_len[fill_idx]   = fill_pos;
            fill_idx = (fill_idx + 1) % tfc_pkg::SLOTS;
            fill_pos = 0;
         end
      end else begin
         n_fetches++;
         found = -1;
         for (s = 0; s < tfc_pkg::SLOTS; s++)
            if (found < 0 && cache_valid[s] && cache_tag[s] == it.device_address)
               found = s;
         if (found < 0) begin
            n_misses++;
            r.hit      = 1'b0;
            r.out_byte = 8'h00;
            r.out_last = 1'b1;
            owed_rsp.push_back(r);
         end else begin
            n_hits++;
            cache_valid[found] = 1'b0;
            // an empty frame still closes with one result
            if (cache_len[found] == 0) begin
               r.hit      = 1'b1;
               r.out_byte = 8'h00;
               r.out_last = 1'b1;
               owed_rsp.push_back(r);
            end
            for (s = 0; s < cache_len[found]; s++) begin
               r.hit      = 1'b1;
               r.out_byte = cache_bytes[found][s];
               r.out_last = (s == cache_len[found] - 1);
               owed_rsp.push_back(r);
            end
         end
      end
   endtask

   function automatic void push_store(logic [7:0] addr, logic [7:0] data, logic last);
      tfc_pkg::req_type it;
      it.kind           = tfc_pkg::KIND_STORE;
      it.device_address = addr;
      it.frame_byte     = data;
      it.frame_end      = last;
      item_q.push_back(it);
   endfunction

   // byte and end mark are don't-care on a fetch, so they are randomized
   function automatic void push_fetch(logic [7:0] addr);
      tfc_pkg::req_type it;
      it.kind           = tfc_pkg::KIND_FETCH;
      it.device_address = addr;
      it.frame_byte     = 8'($urandom_range(0, 255));
      it.frame_end      = 1'($urandom_range(0, 1));
      item_q.push_back(it);
   endfunction

   // small tag pool so that hits and duplicate tags are common
   function automatic logic [7:0] pick_tag();
      case ($urandom_range(0, 4))
         0: return 8'h3C;
         1: return 8'hC3;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int frame_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 84) return $urandom_range(1, 8);
      if (roll < 96) return $urandom_range(9, tfc_pkg::FRAME_BYTES);
      return $urandom_range(tfc_pkg::FRAME_BYTES + 1, tfc_pkg::FRAME_BYTES + 8);
   endfunction

   // Only the end byte's address tags the slot; the others are random.
   // Fetches are sometimes slipped in mid-frame to hit a slot being refilled.
   function automatic void push_frame(logic [7:0] tag, int len);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 8)
            push_fetch(pick_tag());
         push_store((i == len - 1) ? tag : 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), i == len - 1);
      end
   endfunction

   // driver: offers the head of item_q, idling at random outside a calm window
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            cache_take_item(req_item);
            void'(item_q.pop_front());
            n_taken++;
         end
         if (!start || !busy) begin
            if (item_q.size() != 0 &&
                ((n_taken >= 130 && n_taken < 220) || $urandom_range(0, 99) >= 19)) begin
               start    <= 1'b1;
               req_item <= item_q[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed result must match the oldest owed one
   always @(posedge clock) begin
      tfc_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (owed_rsp.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result, expected none, got hit=%b byte=%02h last=%b",
                     $time, rsp_item.hit, rsp_item.out_byte, rsp_item.out_last);
         end else begin
            want = owed_rsp.pop_front();
            n_results++;
            if (rsp_item.hit !== want.hit) begin
               n_errors++;
               $display("%0t: hit expected %b got %b", $time, want.hit, rsp_item.hit);
            end
            if (rsp_item.out_byte !== want.out_byte) begin
               n_errors++;
               $display("%0t: out_byte expected %02h got %02h",
                        $time, want.out_byte, rsp_item.out_byte);
            end
            if (rsp_item.out_last !== want.out_last) begin
               n_errors++;
               $display("%0t: out_last expected %b got %b",
                        $time, want.out_last, rsp_item.out_last);
            end
         end
      end
   end

   // watchdog on cycles with neither an item taken nor a result shown
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d items and %0d results pending",
                     $time, STALL_LIMIT, item_q.size(), owed_rsp.size());
            $display("CHECK FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      int roll;
      // empty cache, single-byte frame, refetch after invalidate
      push_fetch(8'h00);
      push_store(8'hFF, 8'hFF, 1'b1);
      push_fetch(8'hFF);
      push_fetch(8'hFF);
      // earlier byte addresses must not tag the slot
      push_store(8'h12, 8'h00, 1'b0);
      push_store(8'h34, 8'h5A, 1'b0);
      push_store(8'h00, 8'hA5, 1'b1);
      push_fetch(8'h12);
      push_fetch(8'h00);
      // fill slots 2..9, wrap, then slots 0 and 1
      push_store(8'hE1, 8'h11, 1'b1); // actually tag 0x77 below
      item_q[item_q.size() - 1].device_address = 8'h77;
      push_store(8'h77, 8'h22, 1'b1);
      for (int i = 4; i < tfc_pkg::SLOTS; i++)
         push_store(8'hC0 + 8'(i), 8'(i), 1'b1);
      push_store(8'hD0, 8'h80, 1'b1);
      push_store(8'hD1, 8'h01, 1'b1);
      // refill slot 2 while still valid; a fetch now sees the new first byte,
      // and both slot 2 and slot 3 match so the lower one goes first
      push_store(8'h00, 8'h81, 1'b0);
      push_store(8'hFF, 8'h7E, 1'b0);
      push_fetch(8'h77);
      push_fetch(8'h77);
      push_store(8'h77, 8'hC3, 1'b1);
      push_fetch(8'h77);
      push_fetch(8'h77);

      // random part: one overlong frame whose end byte is dropped, then a mix
      push_frame(pick_tag(), tfc_pkg::FRAME_BYTES + 2);
      while (item_q.size() < 325) begin
         roll = $urandom_range(0, 99);
         if (roll < 70)
            push_frame(pick_tag(), frame_len());
         else if (roll < 92)
            push_fetch(pick_tag());
         else
            push_store(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (item_q.size() != 0) @(posedge clock);
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("%0d items taken: %0d store bytes (%0d dropped past frame end), %0d fetches",
               n_taken, n_stores, n_dropped, n_fetches);
      $display("%0d hits, %0d misses, %0d result bytes compared, %0d mismatches",
               n_hits, n_misses, n_results, n_errors);
      if (n_errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
